/* hdl/polyline_arrow_marker_placer_assert.svh */
// assertion macros for the polyline arrow marker placer
`ifndef POLYLINE_ARROW_MARKER_PLACER_ASSERT_SVH
`define POLYLINE_ARROW_MARKER_PLACER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PAMA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define PAMA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define PAMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PAMA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define PAMA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define PAMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/pama_pkg.sv */
// shared types and constants for the polyline arrow marker placer
`timescale 1ns / 1ps
package pama_pkg;
  localparam int OUT_W       = 17;
  localparam int ALEN_W      = 8;
  localparam int SPC_W       = 12;
  localparam int ACC_W       = 32;
  localparam int MAX_ARROWS  = 64;
  localparam int CNT_W       = 7;
  localparam int CFG_W       = 12;

  localparam logic [ALEN_W-1:0] ARROW_LEN_RST = 8'd10;
  localparam logic [SPC_W-1:0]  SPACING_RST   = 12'd100;

  typedef logic signed [OUT_W-1:0] coord_t;

  typedef enum logic {
    REG_ARROW_LENGTH   = 1'b0,
    REG_MARKER_SPACING = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MULX, S_MULY, S_SQLD, S_SQRT, S_SEG,
    S_PREP, S_DLD, S_DIV, S_CHECK, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    J_TX, J_TY, J_HX, J_HY, J_BX, J_BY, J_SKIP
  } job_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

/* hdl/pama_if.sv */
// request channel interfaces for vertices and arrows
`timescale 1ns / 1ps
interface pama_in_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         line_start;
  modport source (output valid, vertex_x, vertex_y, line_start, input ready);
  modport sink   (input valid, vertex_x, vertex_y, line_start, output ready);
endinterface

interface pama_out_if;
  logic                 valid;
  logic                 ready;
  pama_pkg::coord_t     base_x;
  pama_pkg::coord_t     base_y;
  pama_pkg::coord_t     left_x;
  pama_pkg::coord_t     left_y;
  pama_pkg::coord_t     tip_x;
  pama_pkg::coord_t     tip_y;
  pama_pkg::coord_t     right_x;
  pama_pkg::coord_t     right_y;
  logic                 last_arrow;
  modport source (output valid, base_x, base_y, left_x, left_y, tip_x, tip_y,
                  right_x, right_y, last_arrow, input ready);
  modport sink   (input valid, base_x, base_y, left_x, left_y, tip_x, tip_y,
                  right_x, right_y, last_arrow, output ready);
endinterface

/* hdl/pama_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pama_div #(
  parameter int NW = 34,
  parameter int DW = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pama_pkg::div_ctl_t ctl,
  input  logic [NW-1:0]      num,
  input  logic [DW-1:0]      den,
  output pama_pkg::div_sts_t sts,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial   = {rem_r, acc_r[NW-1]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    acc_nxt = {acc_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = acc_r;
  assign rem      = rem_r;
endmodule

/* hdl/polyline_arrow_marker_placer.sv */
// polyline arrow marker placer top level
//
// in_vtx takes one polyline vertex per request (x, y, line start). The first
// vertex of a line is only stored; each later one closes a segment whose
// length is found with a bit-serial square root. Four per-segment arrow
// offsets then go through the shared bit-serial divider, and every arrow
// needs two more divisions for its base. The divider is NW bits wide (NW is
// about 2*COORD_BITS+2*FRAC_BITS+2, 34 by default). A vertex gives up to 64
// arrows; a vertex that closes no segment is taken without leaving idle.
// in_vtx.ready is high only while no vertex is in work.
// out_arw carries one arrow per request from an output register; the next
// arrow is worked out while it waits, and the sequencer holds only when a
// second arrow is ready before the first is taken. last_arrow marks the
// final arrow of a vertex.
// cfg_we writes arrow length (index 0) or marker spacing (index 1) at once.
// After reset (rst_n low, synchronous) no vertex is stored, lengths are zero,
// arrow length is 10 and spacing is 100.
`timescale 1ns / 1ps
`include "polyline_arrow_marker_placer_assert.svh"
module polyline_arrow_marker_placer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pama_in_if.sink                       in_vtx,
  pama_out_if.source                    out_arw,
  input  logic                          cfg_we,
  input  pama_pkg::cfg_idx_t            cfg_index,
  input  logic [pama_pkg::CFG_W-1:0]    cfg_wdata
);
  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int OW   = pama_pkg::OUT_W;
  localparam int AW   = pama_pkg::ACC_W;
  localparam int LW   = C + 1 + F;
  localparam int SQW  = 2 * LW;
  localparam int D2W  = 2 * C + 1;
  localparam int PW   = LW + C;
  localparam int GW   = pama_pkg::SPC_W + F;
  localparam int NWB  = LW + C + F + 1;
  localparam int NWT  = pama_pkg::ALEN_W + C + 2 * F + 1;
  localparam int NW   = (NWB > NWT) ? NWB : NWT;
  localparam int DW   = ((LW + 1) > GW) ? (LW + 1) : GW;
  localparam int SCW  = $clog2(LW);
  localparam int CNW  = pama_pkg::CNT_W;

  pama_pkg::state_t state_r, state_nxt;
  pama_pkg::job_t   job_r, job_nxt;

  logic                          have_r, have_nxt;
  logic signed [C-1:0]           prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [C-1:0]           x0_r, x0_nxt, y0_r, y0_nxt;
  logic [C-1:0]                  mx_r, mx_nxt, my_r, my_nxt;
  logic                          sx_r, sx_nxt, sy_r, sy_nxt;
  logic [D2W-1:0]                d2_r, d2_nxt;
  logic [SQW-1:0]                rad_r, rad_nxt;
  logic [LW+1:0]                 srem_r, srem_nxt;
  logic [LW-1:0]                 root_r, root_nxt;
  logic [SCW-1:0]                sq_cnt_r, sq_cnt_nxt;
  logic [AW-1:0]                 total_r, total_nxt, ssl_r, ssl_nxt;
  logic [AW-1:0]                 nmp_r, nmp_nxt, ofs_r, ofs_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  pama_pkg::coord_t              tx_r, tx_nxt, ty_r, ty_nxt, hx_r, hx_nxt, hy_r, hy_nxt;
  pama_pkg::coord_t              bx_r, bx_nxt, by_r, by_nxt;
  logic [CNW-1:0]                cnt_r, cnt_nxt;
  logic [pama_pkg::ALEN_W-1:0]   alen_r;
  logic [pama_pkg::SPC_W-1:0]    spc_r;

  logic                          ov_r, ov_nxt, oload;
  pama_pkg::coord_t              o_bx_r, o_by_r, o_lx_r, o_ly_r;
  pama_pkg::coord_t              o_tx_r, o_ty_r, o_rx_r, o_ry_r;
  logic                          o_last_r, o_last_nxt;

  // datapath helpers
  logic signed [C:0]             dx, dy;
  logic [C:0]                    adx, ady;
  logic [LW-1:0]                 mul_a;
  logic [C-1:0]                  mul_b;
  logic [PW-1:0]                 mul_p;
  logic [LW+2:0]                 sq_t, sq_trial, sq_diff;
  logic [AW-1:0]                 len32, ofs_step;
  logic [GW-1:0]                 gap;
  logic [pama_pkg::SPC_W-1:0]    spc_eff;
  logic [NW-1:0]                 div_num, prod_w;
  logic [DW-1:0]                 div_den;
  logic [NW-1:0]                 div_q;
  logic [DW-1:0]                 div_r;
  pama_pkg::div_ctl_t            div_ctl;
  pama_pkg::div_sts_t            div_sts;
  logic [OW-1:0]                 q17;
  logic                          res_neg;
  pama_pkg::coord_t              res;
  logic signed [C+F-1:0]         x0f, y0f;
  logic                          in_range;
  logic [LW-1:0]                 skip_num;

  pama_div #(.NW(NW), .DW(DW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (div_den),
    .sts  (div_sts),
    .quo  (div_q),
    .rem  (div_r)
  );

  always_comb begin
    dx      = {in_vtx.vertex_x[C-1], in_vtx.vertex_x} - {prev_x_r[C-1], prev_x_r};
    dy      = {in_vtx.vertex_y[C-1], in_vtx.vertex_y} - {prev_y_r[C-1], prev_y_r};
    adx     = dx[C] ? -dx : dx;
    ady     = dy[C] ? -dy : dy;
    len32   = AW'(root_r);
    spc_eff = (spc_r == '0) ? pama_pkg::SPC_W'(1) : spc_r;
    gap     = GW'(spc_eff) << F;
    ofs_step = ofs_r + AW'(gap);
    in_range = ofs_r <= len32;
    x0f     = signed'({x0_r, {F{1'b0}}});
    y0f     = signed'({y0_r, {F{1'b0}}});
    sq_t     = {srem_r[LW:0], rad_r[SQW-1 -: 2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_diff  = sq_t - sq_trial;
    q17     = div_q[OW-1:0];
    res_neg = (job_r == pama_pkg::J_TX || job_r == pama_pkg::J_HX ||
               job_r == pama_pkg::J_BX) ? sx_r : sy_r;
    res     = res_neg ? pama_pkg::coord_t'(-q17) : pama_pkg::coord_t'(q17);
    skip_num = root_r - ofs_r[LW-1:0];
    prod_w  = NW'(prod_r);
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = LW'(mx_r);
    mul_b = mx_r;
    case (state_r)
      pama_pkg::S_MULY: begin
        mul_a = LW'(my_r);
        mul_b = my_r;
      end
      pama_pkg::S_PREP: begin
        if (job_r == pama_pkg::J_BX || job_r == pama_pkg::J_BY) begin
          mul_a = ofs_r[LW-1:0];
        end else begin
          mul_a = LW'(alen_r);
        end
        if (job_r == pama_pkg::J_TX || job_r == pama_pkg::J_HX ||
            job_r == pama_pkg::J_BX) begin
          mul_b = mx_r;
        end else begin
          mul_b = my_r;
        end
      end
      default: begin
        mul_a = LW'(mx_r);
        mul_b = mx_r;
      end
    endcase
    mul_p = PW'(mul_a * mul_b);
  end

  // divider operand set-up
  always_comb begin
    case (job_r)
      pama_pkg::J_TX, pama_pkg::J_TY: begin
        div_num = (prod_w << (2 * F)) + NW'(root_r >> 1);
        div_den = DW'(root_r);
      end
      pama_pkg::J_HX, pama_pkg::J_HY: begin
        div_num = (prod_w << (2 * F)) + NW'(root_r);
        div_den = DW'(root_r) << 1;
      end
      pama_pkg::J_BX, pama_pkg::J_BY: begin
        div_num = (prod_w << F) + NW'(root_r >> 1);
        div_den = DW'(root_r);
      end
      default: begin
        div_num = NW'(skip_num);
        div_den = DW'(gap);
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    have_nxt    = have_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    x0_nxt      = x0_r;
    y0_nxt      = y0_r;
    mx_nxt      = mx_r;
    my_nxt      = my_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    d2_nxt      = d2_r;
    rad_nxt     = rad_r;
    srem_nxt    = srem_r;
    root_nxt    = root_r;
    sq_cnt_nxt  = sq_cnt_r;
    total_nxt   = total_r;
    ssl_nxt     = ssl_r;
    nmp_nxt     = nmp_r;
    ofs_nxt     = ofs_r;
    prod_nxt    = prod_r;
    tx_nxt      = tx_r;
    ty_nxt      = ty_r;
    hx_nxt      = hx_r;
    hy_nxt      = hy_r;
    bx_nxt      = bx_r;
    by_nxt      = by_r;
    cnt_nxt     = cnt_r;
    o_last_nxt  = 1'b0;
    oload       = 1'b0;
    div_ctl.start = 1'b0;
    in_vtx.ready  = (state_r == pama_pkg::S_IDLE);

    case (state_r)
      pama_pkg::S_IDLE: begin
        if (in_vtx.valid) begin
          prev_x_nxt = in_vtx.vertex_x;
          prev_y_nxt = in_vtx.vertex_y;
          cnt_nxt    = '0;
          if (in_vtx.line_start || !have_r) begin
            have_nxt  = 1'b1;
            total_nxt = '0;
            ssl_nxt   = '0;
            nmp_nxt   = '0;
          end else if (dx != '0 || dy != '0) begin
            x0_nxt    = prev_x_r;
            y0_nxt    = prev_y_r;
            mx_nxt    = adx[C-1:0];
            my_nxt    = ady[C-1:0];
            sx_nxt    = dx[C];
            sy_nxt    = dy[C];
            state_nxt = pama_pkg::S_MULX;
          end
        end
      end
      pama_pkg::S_MULX: begin
        d2_nxt    = D2W'(mul_p);
        state_nxt = pama_pkg::S_MULY;
      end
      pama_pkg::S_MULY: begin
        d2_nxt    = d2_r + D2W'(mul_p);
        state_nxt = pama_pkg::S_SQLD;
      end
      pama_pkg::S_SQLD: begin
        rad_nxt    = SQW'(d2_r) << (2 * F);
        srem_nxt   = '0;
        root_nxt   = '0;
        sq_cnt_nxt = '0;
        state_nxt  = pama_pkg::S_SQRT;
      end
      pama_pkg::S_SQRT: begin
        rad_nxt = rad_r << 2;
        if (sq_t >= sq_trial) begin
          srem_nxt = sq_diff[LW+1:0];
          root_nxt = {root_r[LW-2:0], 1'b1};
        end else begin
          srem_nxt = sq_t[LW+1:0];
          root_nxt = {root_r[LW-2:0], 1'b0};
        end
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r == SCW'(LW - 1)) begin
          state_nxt = pama_pkg::S_SEG;
        end
      end
      pama_pkg::S_SEG: begin
        ssl_nxt   = total_r;
        total_nxt = total_r + len32;
        ofs_nxt   = nmp_r - total_r;
        job_nxt   = pama_pkg::J_TX;
        state_nxt = pama_pkg::S_PREP;
      end
      pama_pkg::S_PREP: begin
        prod_nxt  = mul_p;
        state_nxt = pama_pkg::S_DLD;
      end
      pama_pkg::S_DLD: begin
        div_ctl.start = 1'b1;
        state_nxt     = pama_pkg::S_DIV;
      end
      pama_pkg::S_DIV: begin
        if (div_sts.done) begin
          state_nxt = pama_pkg::S_PREP;
          case (job_r)
            pama_pkg::J_TX: begin
              tx_nxt  = res;
              job_nxt = pama_pkg::J_TY;
            end
            pama_pkg::J_TY: begin
              ty_nxt  = res;
              job_nxt = pama_pkg::J_HX;
            end
            pama_pkg::J_HX: begin
              hx_nxt  = res;
              job_nxt = pama_pkg::J_HY;
            end
            pama_pkg::J_HY: begin
              hy_nxt    = res;
              state_nxt = pama_pkg::S_CHECK;
            end
            pama_pkg::J_BX: begin
              bx_nxt  = pama_pkg::coord_t'(x0f) + res;
              job_nxt = pama_pkg::J_BY;
            end
            pama_pkg::J_BY: begin
              by_nxt    = pama_pkg::coord_t'(y0f) + res;
              state_nxt = pama_pkg::S_EMIT;
            end
            default: begin
              nmp_nxt   = nmp_r + AW'(skip_num) - AW'(div_r) + AW'(gap);
              state_nxt = pama_pkg::S_IDLE;
            end
          endcase
        end
      end
      pama_pkg::S_CHECK: begin
        if (in_range && cnt_r < CNW'(pama_pkg::MAX_ARROWS)) begin
          job_nxt   = pama_pkg::J_BX;
          state_nxt = pama_pkg::S_PREP;
        end else if (in_range) begin
          job_nxt   = pama_pkg::J_SKIP;
          state_nxt = pama_pkg::S_DLD;
        end else begin
          state_nxt = pama_pkg::S_IDLE;
        end
      end
      pama_pkg::S_EMIT: begin
        if (!ov_r || out_arw.ready) begin
          oload      = 1'b1;
          o_last_nxt = (cnt_r == CNW'(pama_pkg::MAX_ARROWS - 1)) || (ofs_step > len32);
          cnt_nxt    = cnt_r + 1'b1;
          nmp_nxt    = nmp_r + AW'(gap);
          ofs_nxt    = ofs_step;
          state_nxt  = pama_pkg::S_CHECK;
        end
      end
      default: begin
        state_nxt = pama_pkg::S_IDLE;
      end
    endcase

    ov_nxt = oload ? 1'b1 : (out_arw.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pama_pkg::S_IDLE;
      job_r    <= pama_pkg::J_TX;
      have_r   <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      total_r  <= '0;
      ssl_r    <= '0;
      nmp_r    <= '0;
      ofs_r    <= '0;
      cnt_r    <= '0;
      sq_cnt_r <= '0;
      ov_r     <= 1'b0;
      alen_r   <= pama_pkg::ARROW_LEN_RST;
      spc_r    <= pama_pkg::SPACING_RST;
    end else begin
      state_r  <= state_nxt;
      job_r    <= job_nxt;
      have_r   <= have_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      total_r  <= total_nxt;
      ssl_r    <= ssl_nxt;
      nmp_r    <= nmp_nxt;
      ofs_r    <= ofs_nxt;
      cnt_r    <= cnt_nxt;
      sq_cnt_r <= sq_cnt_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pama_pkg::REG_ARROW_LENGTH:   alen_r <= cfg_wdata[pama_pkg::ALEN_W-1:0];
          pama_pkg::REG_MARKER_SPACING: spc_r  <= cfg_wdata[pama_pkg::SPC_W-1:0];
          default: begin
            alen_r <= alen_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x0_r   <= x0_nxt;
    y0_r   <= y0_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    d2_r   <= d2_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    prod_r <= prod_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    hx_r   <= hx_nxt;
    hy_r   <= hy_nxt;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    if (oload) begin
      o_bx_r   <= bx_r;
      o_by_r   <= by_r;
      o_lx_r   <= bx_r - hy_r;
      o_ly_r   <= by_r + hx_r;
      o_tx_r   <= bx_r + tx_r;
      o_ty_r   <= by_r + ty_r;
      o_rx_r   <= bx_r + hy_r;
      o_ry_r   <= by_r - hx_r;
      o_last_r <= o_last_nxt;
    end
  end

  assign out_arw.valid      = ov_r;
  assign out_arw.base_x     = o_bx_r;
  assign out_arw.base_y     = o_by_r;
  assign out_arw.left_x     = o_lx_r;
  assign out_arw.left_y     = o_ly_r;
  assign out_arw.tip_x      = o_tx_r;
  assign out_arw.tip_y      = o_ty_r;
  assign out_arw.right_x    = o_rx_r;
  assign out_arw.right_y    = o_ry_r;
  assign out_arw.last_arrow = o_last_r;

  `PAMA_ASSERT_ALWAYS(a_cnt_max, clk, rst_n, cnt_r <= CNW'(pama_pkg::MAX_ARROWS), "arrow count overrun")
  `PAMA_ASSERT_IMPLY(a_div_done, clk, rst_n, div_sts.done, state_r == pama_pkg::S_DIV, "divider result unclaimed")
  `PAMA_ASSERT_IMPLY(a_div_start, clk, rst_n, div_ctl.start, !div_sts.busy, "divider restarted while busy")
  `PAMA_ASSERT_IMPLY(a_ofs_track, clk, rst_n, state_r == pama_pkg::S_CHECK, ofs_r == (nmp_r - ssl_r), "marker offset out of step")
  `PAMA_ASSERT_NEXT(a_emit_load, clk, rst_n, (state_r == pama_pkg::S_EMIT) && (!ov_r || out_arw.ready), ov_r, "arrow not presented")
endmodule

/* tb/polyline_arrow_marker_placer_test.sv */
// self-checking testbench for the polyline arrow marker placer
`timescale 1ns / 1ps
module polyline_arrow_marker_placer_test;
  typedef logic [8:0][pama_pkg::OUT_W-1:0] arrow_t;
  typedef struct {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic               line_start;
    bit                 hold;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  pama_pkg::cfg_idx_t cfg_index = pama_pkg::REG_ARROW_LENGTH;
  logic [pama_pkg::CFG_W-1:0] cfg_wdata = '0;

  pama_in_if #(.COORD_BITS(12)) vtx_if ();
  pama_out_if arw_if ();

  polyline_arrow_marker_placer #(.COORD_BITS(12), .FRAC_BITS(4)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_vtx(vtx_if), .out_arw(arw_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  vertex_t vertex_q[$];
  arrow_t  arrow_q[$];
  int      errors = 0;
  bit      no_idle = 1'b0;

  // predictor state
  logic [7:0]  mdl_alen = 8'd10;
  logic [11:0] mdl_spacing = 12'd100;
  int          mdl_px = 0;
  int          mdl_py = 0;
  logic [31:0] mdl_seg_start = '0;
  logic [31:0] mdl_total = '0;
  logic [31:0] mdl_next_mark = '0;
  bit          mdl_have = 1'b0;

  string field_name[9] = '{"base_x", "base_y", "left_x", "left_y", "tip_x", "tip_y",
                           "right_x", "right_y", "last_arrow"};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = num < 0 ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic place_arrows(vertex_t v);
    longint x0, y0, dx, dy, a, bx, by, hx, hy, tx, ty, lenl;
    longint unsigned d2, len, k;
    logic [31:0] gap, offset;
    arrow_t arw;
    int cnt;
    cnt = 0;
    if (v.line_start || !mdl_have) begin
      mdl_px = v.x;
      mdl_py = v.y;
      mdl_seg_start = '0;
      mdl_total = '0;
      mdl_next_mark = '0;
      mdl_have = 1'b1;
      return;
    end
    x0 = mdl_px;
    y0 = mdl_py;
    dx = longint'(v.x) - x0;
    dy = longint'(v.y) - y0;
    mdl_px = v.x;
    mdl_py = v.y;
    d2 = dx * dx + dy * dy;
    if (d2 == 0) return;
    len = int_sqrt(d2 << 8);
    lenl = longint'(len);
    mdl_seg_start = mdl_total;
    mdl_total = mdl_seg_start + len[31:0];
    gap = {16'd0, (mdl_spacing != 0 ? mdl_spacing : 12'd1), 4'd0};
    a = longint'(mdl_alen);
    offset = mdl_next_mark - mdl_seg_start;
    while (longint'(offset) <= lenl && cnt < pama_pkg::MAX_ARROWS) begin
      bx = x0 * 16 + round_div(longint'(offset) * dx * 16, len);
      by = y0 * 16 + round_div(longint'(offset) * dy * 16, len);
      hx = round_div(a * dx * 256, 2 * len);
      hy = round_div(a * dy * 256, 2 * len);
      tx = round_div(a * dx * 256, len);
      ty = round_div(a * dy * 256, len);
      arw[0] = bx[16:0];
      arw[1] = by[16:0];
      arw[2] = (bx - hy) & 17'h1ffff;
      arw[3] = (by + hx) & 17'h1ffff;
      arw[4] = (bx + tx) & 17'h1ffff;
      arw[5] = (by + ty) & 17'h1ffff;
      arw[6] = (bx + hy) & 17'h1ffff;
      arw[7] = (by - hx) & 17'h1ffff;
      arw[8] = '0;
      arrow_q.push_back(arw);
      cnt++;
      mdl_next_mark = mdl_next_mark + gap;
      offset = mdl_next_mark - mdl_seg_start;
    end
    if (longint'(offset) <= lenl) begin
      k = (len - longint'(offset)) / gap + 1;
      mdl_next_mark = mdl_next_mark + 32'(k * gap);
    end
    if (cnt > 0) arrow_q[arrow_q.size() - 1][8] = 17'd1;
  endtask

  // request driver
  int send_gap = 0;
  always @(posedge clk) begin
    logic sending;
    vertex_t cur;
    sending = vtx_if.valid;
    if (!rst_n) begin
      sending = 1'b0;
    end else begin
      if (vtx_if.valid && vtx_if.ready) begin
        cur.x = vtx_if.vertex_x;
        cur.y = vtx_if.vertex_y;
        cur.line_start = vtx_if.line_start;
        place_arrows(cur);
        sending = 1'b0;
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (vertex_q.size() > 0 && !(vertex_q[0].hold && arrow_q.size() != 0)) begin
          cur = vertex_q.pop_front();
          vtx_if.vertex_x <= cur.x;
          vtx_if.vertex_y <= cur.y;
          vtx_if.line_start <= cur.line_start;
          sending = 1'b1;
          send_gap = no_idle ? 0 : $urandom_range(0, 17);
        end
      end
    end
    vtx_if.valid <= sending;
  end

  // arrow monitor
  int stall = 0;
  always @(posedge clk) begin
    arrow_t got;
    arrow_t want;
    if (!rst_n) begin
      arw_if.ready <= 1'b0;
    end else begin
      if (arw_if.valid && arw_if.ready) begin
        got = {{16'd0, arw_if.last_arrow}, arw_if.right_y, arw_if.right_x, arw_if.tip_y,
               arw_if.tip_x, arw_if.left_y, arw_if.left_x, arw_if.base_y, arw_if.base_x};
        if (arrow_q.size() == 0) begin
          $display("%0t: unexpected arrow, actual base %0h/%0h", $time, got[0], got[1]);
          errors++;
        end else begin
          want = arrow_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[i] !== want[i]) begin
              $display("%0t: %s expected %0h actual %0h", $time, field_name[i], want[i],
                       got[i]);
              errors++;
            end
        end
        stall = no_idle ? 0 : $urandom_range(0, 17);
      end
      arw_if.ready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(pama_pkg::cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= pama_pkg::CFG_W'(val);
    if (idx == pama_pkg::REG_ARROW_LENGTH) mdl_alen = val[7:0];
    else mdl_spacing = val[11:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_vertex(int x, int y, bit ls, bit hold = 1'b0);
    vertex_t v;
    v.x = x[11:0];
    v.y = y[11:0];
    v.line_start = ls;
    v.hold = hold;
    vertex_q.push_back(v);
  endtask

  task automatic drain();
    while (vertex_q.size() != 0 || vtx_if.valid || arrow_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic int clamp(int v);
    return v > 2047 ? 2047 : (v < -2048 ? -2048 : v);
  endfunction

  task automatic random_phase(int alen, int spc, int n, int step, bit quiet);
    int x, y, left;
    x = 0;
    y = 0;
    left = 0;
    no_idle = quiet;
    write_reg(pama_pkg::REG_ARROW_LENGTH, alen);
    write_reg(pama_pkg::REG_MARKER_SPACING, spc);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any vertex, any line start
        add_vertex($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                   $urandom_range(0, 1), i == n / 2);
        left = 0;
        x = 0;
        y = 0;
      end else if (left == 0) begin
        x = $urandom_range(0, 4095) - 2048;
        y = $urandom_range(0, 4095) - 2048;
        add_vertex(x, y, 1'b1, i == n / 2);
        left = $urandom_range(2, 8);
      end else begin
        if ($urandom_range(0, 15) != 0) begin
          x = clamp(x + $urandom_range(0, 2 * step) - step);
          y = clamp(y + $urandom_range(0, 2 * step) - step);
        end
        add_vertex(x, y, 1'b0, i == n / 2);
        left--;
      end
    end
    drain();
  endtask

  initial begin
    vtx_if.valid = 1'b0;
    vtx_if.vertex_x = '0;
    vtx_if.vertex_y = '0;
    vtx_if.line_start = 1'b0;
    arw_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, corners and zero-length segments
    add_vertex(0, 0, 1'b1);
    add_vertex(2047, 2047, 1'b0);
    add_vertex(-2048, -2048, 1'b0);
    add_vertex(-2048, -2048, 1'b0);
    add_vertex(-2048, 2047, 1'b0);
    add_vertex(2047, -2048, 1'b1);
    add_vertex(2047, -2048, 1'b0);
    add_vertex(2040, -2000, 1'b0);
    add_vertex(-5, 3, 1'b0, 1'b1);
    drain();
    // marker cap and longest arrows
    write_reg(pama_pkg::REG_ARROW_LENGTH, 255);
    write_reg(pama_pkg::REG_MARKER_SPACING, 1);
    add_vertex(0, 0, 1'b1);
    add_vertex(2047, 0, 1'b0);
    add_vertex(2047, 5, 1'b0);
    add_vertex(-2048, 2047, 1'b0);
    drain();
    // zero arrow length and zero spacing
    write_reg(pama_pkg::REG_ARROW_LENGTH, 0);
    write_reg(pama_pkg::REG_MARKER_SPACING, 0);
    add_vertex(5, 5, 1'b1);
    add_vertex(9, 8, 1'b0);
    add_vertex(9, 8, 1'b0);
    add_vertex(-3, 1, 1'b0);
    drain();

    random_phase(10, 100, 70, 300, 1'b0);
    random_phase(255, 4095, 70, 2047, 1'b1);
    random_phase(1, 1, 70, 12, 1'b0);
    random_phase(0, 0, 60, 3, 1'b0);
    random_phase(128, 37, 70, 120, 1'b0);
    random_phase($urandom_range(1, 255), $urandom_range(20, 4095), 70, 500, 1'b0);

    if (errors == 0 && arrow_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hdl
hdl/pama_pkg.sv
hdl/pama_if.sv
hdl/pama_div.sv
hdl/polyline_arrow_marker_placer.sv
tb/polyline_arrow_marker_placer_test.sv
